>>> design/assert_macros.svh
// Assertion macros shared by the LED matrix row scanner RTL.
// Depends on nothing; each user supplies clk and rst_n in its own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/lmrs_pkg.sv
// Types, constants and the column driver function of the LED matrix row scanner.
// Used by lmrs_frame_buf and led_matrix_row_scanner; depends on nothing.
package lmrs_pkg;

  localparam int unsigned NUM_ROWS = 8;
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0]  MAX_LINES  = 4'd8;
  localparam logic [DATA_W-1:0] PIXEL_MSB  = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_ROW   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ROW_W-1:0]  col_index;
    logic [ROW_W-1:0]  row_index;
    logic [DATA_W-1:0] pixel_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] row_lines;
    logic [DATA_W-1:0] col_lines;
  } out_item_t;

  // Control handed from the top level to the frame buffer.
  typedef struct packed {
    logic             apply;
    logic [CFG_W-1:0] row_limit;
  } fb_ctrl_t;

  function automatic logic [CFG_W-1:0] limit_lines(logic [CFG_W-1:0] v);
    return (v > MAX_LINES) ? MAX_LINES : v;
  endfunction

  // Column lines are active low; column i shows row bit 7-i.
  function automatic logic [DATA_W-1:0] col_drive(logic [DATA_W-1:0] data,
                                                  logic [CFG_W-1:0] cols);
    logic [CFG_W-1:0]  n;
    logic [DATA_W-1:0] lines;
    n = limit_lines(cols);
    lines = '1;
    for (int i = 0; i < DATA_W; i++) begin
      if (data[DATA_W-1-i] && (CFG_W'(i) < n)) begin
        lines[i] = 1'b0;
      end
    end
    return lines;
  endfunction

endpackage

>>> design/lmrs_frame_buf.sv
// Frame buffer, active row counter and shadow of the active row's contents.
// Depends on lmrs_pkg.
module lmrs_frame_buf import lmrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fb_ctrl_t                ctrl,
  input  in_item_t                item,
  output logic [ROW_W-1:0]        show_row,
  output logic [DATA_W-1:0]       show_data
);

  logic [DATA_W-1:0] frame_r [NUM_ROWS];
  logic [ROW_W-1:0]  active_r;
  logic [DATA_W-1:0] cur_r;

  logic [CFG_W-1:0]  row_inc;
  logic [ROW_W-1:0]  tick_row;
  logic [ROW_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] wr_val;

  // One read port serves both the pixel read-modify-write and the tick lookup.
  always_comb begin
    row_inc  = {1'b0, active_r} + CFG_W'(1);
    tick_row = (row_inc >= ctrl.row_limit) ? '0 : row_inc[ROW_W-1:0];
    rd_addr  = (item.cmd == CMD_TICK) ? tick_row : item.row_index;
    rd_data  = frame_r[rd_addr];
    mask     = PIXEL_MSB >> item.col_index;
    wr_val   = '0;
    show_row  = active_r;
    show_data = cur_r;
    case (item.cmd)
      CMD_PIXEL: begin
        wr_val = (rd_data & ~mask) | ((item.pixel_data != '0) ? mask : '0);
        if (item.row_index == active_r) begin
          show_data = wr_val;
        end
      end
      CMD_ROW: begin
        wr_val = item.pixel_data;
        if (item.row_index == active_r) begin
          show_data = wr_val;
        end
      end
      CMD_CLEAR: begin
        show_data = '0;
      end
      default: begin
        show_row  = tick_row;
        show_data = rd_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        frame_r[i] <= '0;
      end
      active_r <= '0;
      cur_r    <= '0;
    end else if (ctrl.apply) begin
      case (item.cmd) inside
        CMD_PIXEL, CMD_ROW: begin
          frame_r[item.row_index] <= wr_val;
        end
        CMD_CLEAR: begin
          for (int i = 0; i < NUM_ROWS; i++) begin
            frame_r[i] <= '0;
          end
        end
        default: begin
          active_r <= tick_row;
        end
      endcase
      cur_r <= show_data;
    end
  end

endmodule

>>> design/led_matrix_row_scanner.sv
// An accepted item is held in the input register; its result is loaded into the
// output register once the output register is free. Throughput: one item per
// cycle while the output is not stalled, set by the single pass from the input
// register through the frame buffer update to the output register.
// Reset clears the frame buffer, the active row and both valid flags, and sets
// both line counts to eight.
//
// Top level of the LED matrix row scanner: input register, config, output register.
// Depends on lmrs_pkg, lmrs_frame_buf and assert_macros.svh.
`include "assert_macros.svh"

module led_matrix_row_scanner import lmrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic             in_vld_r;
  in_item_t         in_item_r;
  logic             out_vld_r;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;
  logic [CFG_W-1:0] rows_in_use_r;
  logic [CFG_W-1:0] cols_in_use_r;
  logic             advance;
  fb_ctrl_t         fb_ctrl;
  logic [ROW_W-1:0]  show_row;
  logic [DATA_W-1:0] show_data;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  assign fb_ctrl.apply     = advance;
  assign fb_ctrl.row_limit = limit_lines(rows_in_use_r);

  lmrs_frame_buf u_frame_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fb_ctrl),
    .item      (in_item_r),
    .show_row  (show_row),
    .show_data (show_data)
  );

  always_comb begin
    out_item_nxt.row_lines = DATA_W'(1) << show_row;
    out_item_nxt.col_lines = col_drive(show_data, cols_in_use_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= MAX_LINES;
      cols_in_use_r <= MAX_LINES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: rows_in_use_r <= cfg_wdata;
        CFG_COLS_IN_USE: cols_in_use_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  `ASSERT_CLK(a_row_onehot, out_vld_r |-> $onehot(out_item_r.row_lines), "Row lines not one-hot.")
  `ASSERT_CLK(a_ready_when_free, !out_vld_r |-> in_ready, "Input stalled with output empty.")
  `ASSERT_CLK(a_advance_loads, advance |=> out_vld_r, "Processed item did not reach the output.")
  `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> (!out_vld_r && !in_vld_r), "Not empty after reset.")

endmodule

>>> bench/led_matrix_row_scanner_test.sv
// Self-checking testbench for the LED matrix row scanner: directed and random commands,
// line-count settings and output back-pressure, each result checked against a local model.
// Depends on lmrs_pkg and the led_matrix_row_scanner RTL only.
module led_matrix_row_scanner_test;
  import lmrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_LEN   = 80;
  localparam int IDLE_LIMIT = 1000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic [DATA_W-1:0] frame_buf [NUM_ROWS] = '{default: 8'h00};
  logic [ROW_W-1:0]  shown_row = '0;
  logic [CFG_W-1:0]  rows_cfg  = 4'd8;
  logic [CFG_W-1:0]  cols_cfg  = 4'd8;
  out_item_t         expected_lines [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;

  led_matrix_row_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_item_t scan_lines(in_item_t it);
    logic [DATA_W-1:0] bitmask;
    logic [CFG_W-1:0]  row_cap;
    logic [CFG_W-1:0]  col_cap;
    logic [CFG_W-1:0]  next_row;
    out_item_t         res;
    case (it.cmd)
      CMD_PIXEL: begin
        bitmask = PIXEL_MSB >> it.col_index;
        frame_buf[it.row_index] = (frame_buf[it.row_index] & ~bitmask) |
                                  ((it.pixel_data != '0) ? bitmask : 8'h00);
      end
      CMD_ROW: begin
        frame_buf[it.row_index] = it.pixel_data;
      end
      CMD_CLEAR: begin
        for (int r = 0; r < NUM_ROWS; r++) frame_buf[r] = 8'h00;
      end
      default: begin
        row_cap  = (rows_cfg > MAX_LINES) ? MAX_LINES : rows_cfg;
        next_row = {1'b0, shown_row} + 4'd1;
        shown_row = (next_row >= row_cap) ? '0 : next_row[ROW_W-1:0];
      end
    endcase
    col_cap = (cols_cfg > MAX_LINES) ? MAX_LINES : cols_cfg;
    res.row_lines = 8'h01 << shown_row;
    res.col_lines = 8'hFF;
    for (int c = 0; c < DATA_W; c++) begin
      if (c < col_cap && frame_buf[shown_row][DATA_W-1-c]) res.col_lines[c] = 1'b0;
    end
    return res;
  endfunction

  function automatic in_item_t make_cmd(cmd_t c, logic [2:0] col, logic [2:0] row,
                                        logic [7:0] data);
    in_item_t it;
    it.cmd        = c;
    it.col_index  = col;
    it.row_index  = row;
    it.pixel_data = data;
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    int pick;
    pick = $urandom_range(99);
    return make_cmd((pick < 35) ? CMD_PIXEL : (pick < 65) ? CMD_ROW :
                    (pick < 70) ? CMD_CLEAR : CMD_TICK,
                    3'($urandom_range(7)), 3'($urandom_range(7)),
                    ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_command(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_lines.push_back(scan_lines(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_line_counts(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_IN_USE;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= CFG_COLS_IN_USE;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_cfg = rows;
    cols_cfg = cols;
  endtask

  // Receiver: random stalls, long holds on request, and the result check.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: rows %h cols %h",
                                  out_data.row_lines, out_data.col_lines));
      end else begin
        if (out_data.row_lines !== expected_lines[0].row_lines)
          report_mismatch($sformatf("row_lines got %h want %h",
                                    out_data.row_lines, expected_lines[0].row_lines));
        if (out_data.col_lines !== expected_lines[0].col_lines)
          report_mismatch($sformatf("col_lines got %h want %h",
                                    out_data.col_lines, expected_lines[0].col_lines));
        void'(expected_lines.pop_front());
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_directed();
    send_idle_pct  = 18;
    recv_stall_pct = 45;
    push_command(make_cmd(CMD_PIXEL, 3'd0, 3'd0, 8'h01));
    push_command(make_cmd(CMD_PIXEL, 3'd7, 3'd0, 8'h80));
    push_command(make_cmd(CMD_PIXEL, 3'd3, 3'd0, 8'hFF));
    push_command(make_cmd(CMD_PIXEL, 3'd0, 3'd0, 8'h00));
    push_command(make_cmd(CMD_PIXEL, 3'd7, 3'd7, 8'h5A));
    push_command(make_cmd(CMD_ROW,   3'd7, 3'd1, 8'hFF));
    push_command(make_cmd(CMD_ROW,   3'd2, 3'd7, 8'hA5));
    push_command(make_cmd(CMD_ROW,   3'd5, 3'd0, 8'h00));
    push_command(make_cmd(CMD_ROW,   3'd0, 3'd0, 8'hFF));
    for (int t = 0; t < 9; t++) begin
      push_command(make_cmd(CMD_TICK, 3'($urandom_range(7)), 3'($urandom_range(7)),
                            8'($urandom)));
    end
    push_command(make_cmd(CMD_CLEAR, 3'd7, 3'd7, 8'hFF));
    push_command(make_cmd(CMD_CLEAR, 3'd0, 3'd0, 8'h00));
    push_command(make_cmd(CMD_ROW,   3'd0, 3'd1, 8'h81));
    push_command(make_cmd(CMD_PIXEL, 3'd6, 3'd1, 8'h10));
    wait_drained();
  endtask

  task automatic test_line_limits();
    send_idle_pct  = 18;
    recv_stall_pct = 45;
    for (int r = 0; r < NUM_ROWS; r++) push_command(make_cmd(CMD_ROW, 3'd0, 3'(r), 8'($urandom)));
    for (int t = 0; t < 6; t++) push_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 8'h00));
    wait_drained();
    // Row count drops below the row on show: it stays until the next tick.
    set_line_counts(4'd3, 4'd8);
    push_command(make_cmd(CMD_ROW, 3'd0, 3'd6, 8'hC3));
    push_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 8'h00));
    push_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 8'h00));
    wait_drained();
    set_line_counts(4'd0, 4'd0);
    for (int t = 0; t < 3; t++) push_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 8'h00));
    push_command(make_cmd(CMD_ROW, 3'd0, 3'd0, 8'hFF));
    wait_drained();
    set_line_counts(4'd15, 4'd15);
    for (int t = 0; t < 9; t++) push_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 8'h00));
    wait_drained();
    set_line_counts(4'd1, 4'd1);
    push_command(make_cmd(CMD_ROW, 3'd0, 3'd0, 8'hFF));
    push_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 8'h00));
    wait_drained();
    set_line_counts(4'd5, 4'd3);
    for (int t = 0; t < 6; t++) push_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 8'h00));
    wait_drained();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int segments,
                                     int per_segment);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int s = 0; s < segments; s++) begin
      set_line_counts(4'($urandom_range(15)), 4'($urandom_range(15)));
      for (int n = 0; n < per_segment; n++) push_command(random_cmd());
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_line_counts(4'd8, 4'd8);
    hold_req <= hold_req + 1;
    for (int n = 0; n < 60; n++) push_command(random_cmd());
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_line_limits();
    test_random_traffic(18, 45, 4, 153);
    test_random_traffic(45, 18, 4, 153);
    test_random_traffic(0, 0, 4, 153);
    test_backpressure();
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
